>>> src/wsml_pkg.sv
// Shared types, codes and defaults for the write-set marker log.
// No dependencies; imported by every module of the block.
package wsml_pkg;

	localparam int TID_W      = 4;
	localparam int ADDR_W     = 48;
	localparam int STATUS_W   = 3;
	localparam int SLOT_OUT_W = 7;

	localparam int MARKER_ENTRIES_DEF   = 1024;
	localparam int LOG_DEPTH_DEF        = 64;
	localparam int THREAD_COUNT_DEF     = 16;
	localparam int LINE_OFFSET_BITS_DEF = 6;

	localparam logic [STATUS_W-1:0] ST_APPENDED  = 3'd0;
	localparam logic [STATUS_W-1:0] ST_LOGGED    = 3'd1;
	localparam logic [STATUS_W-1:0] ST_CONFLICT  = 3'd2;
	localparam logic [STATUS_W-1:0] ST_FULL      = 3'd3;
	localparam logic [STATUS_W-1:0] ST_COMMITTED = 3'd4;

	typedef struct packed {
		logic              kind;
		logic [TID_W-1:0]  thread_id;
		logic [ADDR_W-1:0] byte_address;
	} req_item_t;

	typedef struct packed {
		logic [STATUS_W-1:0]   status;
		logic [SLOT_OUT_W-1:0] log_slot;
	} rsp_item_t;

	typedef enum logic [1:0] {
		SEL_ZERO = 2'd0,
		SEL_FILL = 2'd1,
		SEL_IDX  = 2'd2
	} slot_sel_t;

	// Controller to datapath
	typedef struct packed {
		logic                clr_step;
		logic                accept;
		logic                mod_start;
		logic                mark_rd;
		logic                mark_write;
		logic                log_append;
		logic                set_search;
		logic                commit_start;
		logic                log_rd;
		logic                idx_inc;
		logic                release_mark;
		logic                fill_clear;
		logic                set_res;
		logic [STATUS_W-1:0] res_status;
		slot_sel_t           res_sel;
		logic                out_load;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic clr_last;
		logic tid_ok;
		logic commit;
		logic full;
		logic fill_zero;
		logic mod_done;
		logic owner_free;
		logic owner_mine;
		logic slot_lt_fill;
		logic hit;
		logic idx_last;
		logic out_free;
	} sts_t;

endpackage

>>> src/write_set_marker_log_unit.sv
// Top level of the write-set marker log: controller plus datapath.
// Depends on wsml_pkg, wsml_ctrl, wsml_dp (and wsml_mod below it).
//
// Usage
//   req channel (req_valid/req_ready, payload req): one beat per write or
//   commit. rsp channel (rsp_valid/rsp_ready, payload rsp): exactly one beat
//   per request, in request order.
//   One request is worked on at a time; req_ready is high only while the
//   sequencer is idle.
// Sequence per request:
//   a plain write or a conflict checks the marker table; a full log, an
//   empty commit or an out-of-range thread is answered at decode; an alias
//   search reads log entries one by one from the marked slot; a commit
//   reads each logged entry and frees its marker. The log memory has a
//   single read port. For a table size that is not a power of two the
//   index unit runs an iterative remainder for every write that reaches
//   the marker table.
// Reset: arst_n clears control state and fill counts, then a clearing pass
//   frees the marker table one entry a cycle, with req_ready held low.
// Stalls: a finished response sits in the output register; while rsp_ready
//   is low the next request is still taken and processed, and its response
//   waits until the register is emptied.
module write_set_marker_log_unit #(
	parameter int MARKER_ENTRIES   = wsml_pkg::MARKER_ENTRIES_DEF,
	parameter int LOG_DEPTH        = wsml_pkg::LOG_DEPTH_DEF,
	parameter int THREAD_COUNT     = wsml_pkg::THREAD_COUNT_DEF,
	parameter int LINE_OFFSET_BITS = wsml_pkg::LINE_OFFSET_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	input  wsml_pkg::req_item_t req,
	output logic                rsp_valid,
	input  logic                rsp_ready,
	output wsml_pkg::rsp_item_t rsp
);
	import wsml_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// sequencing only; no payload crosses here
	wsml_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// stores, compares and the output register
	wsml_dp #(
		.MARKER_ENTRIES  (MARKER_ENTRIES),
		.LOG_DEPTH       (LOG_DEPTH),
		.THREAD_COUNT    (THREAD_COUNT),
		.LINE_OFFSET_BITS(LINE_OFFSET_BITS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp      (rsp),
		.cmd      (cmd),
		.sts      (sts)
	);

endmodule

>>> src/wsml_mod.sv
// Marker index unit: line number modulo the marker table size.
// Depends on wsml_pkg. Mask for a power-of-two size, else 4 bits a cycle.
module wsml_mod #(
	parameter int MARKER_ENTRIES = wsml_pkg::MARKER_ENTRIES_DEF,
	parameter int LINE_W         = 42
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [LINE_W-1:0]                 line,
	output logic                              done,
	output logic [$clog2(MARKER_ENTRIES)-1:0] rem
);
	import wsml_pkg::*;

	localparam int MIDX_W = $clog2(MARKER_ENTRIES);
	localparam bit POW2   = (MARKER_ENTRIES & (MARKER_ENTRIES - 1)) == 0;
	localparam int STEPS  = (LINE_W + 3) / 4;
	localparam int PAD_W  = STEPS * 4;
	localparam int CNT_W  = $clog2(STEPS + 1);

	logic              busy_q;
	logic [MIDX_W-1:0] r_q;

	assign done = ~busy_q;
	assign rem  = r_q;

	generate
		if (POW2) begin : g_mask
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					busy_q <= 1'b0;
				end else begin
					busy_q <= 1'b0;
				end
			end
			always_ff @(posedge clk) begin
				if (start) begin
					r_q <= line[MIDX_W-1:0];
				end
			end
		end else begin : g_iter
			localparam logic [MIDX_W:0] MOD_C = (MIDX_W + 1)'(MARKER_ENTRIES);
			logic [PAD_W-1:0]  sh_q, sh_n;
			logic [MIDX_W-1:0] r_n;
			logic [CNT_W-1:0]  cnt_q;

			// restoring remainder, four line bits per step, one per loop pass
			always_comb begin
				logic [MIDX_W:0] t;
				r_n  = r_q;
				sh_n = sh_q;
				for (int k = 0; k < 4; k++) begin
					t    = {r_n, sh_n[PAD_W-1]};
					sh_n = sh_n << 1;
					if (t >= MOD_C) begin
						t = t - MOD_C;
					end
					r_n = t[MIDX_W-1:0];
				end
			end

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					busy_q <= 1'b0;
					cnt_q  <= '0;
				end else if (start) begin
					busy_q <= 1'b1;
					cnt_q  <= CNT_W'(STEPS);
				end else if (busy_q) begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == CNT_W'(1)) begin
						busy_q <= 1'b0;
					end
				end
			end

			always_ff @(posedge clk) begin
				if (start) begin
					sh_q <= PAD_W'(line);
					r_q  <= '0;
				end else if (busy_q) begin
					sh_q <= sh_n;
					r_q  <= r_n;
				end
			end
		end
	endgenerate

endmodule

>>> src/wsml_ctrl.sv
// Sequencer of the marker log: clear sweep, write path, search and commit walks.
// Depends on wsml_pkg; drives the datapath through cmd_t, watches sts_t.
module wsml_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  wsml_pkg::sts_t sts,
	output wsml_pkg::cmd_t cmd
);
	import wsml_pkg::*;

	typedef enum logic [9:0] {
		S_CLR  = 10'b0000000001,
		S_IDLE = 10'b0000000010,
		S_DEC  = 10'b0000000100,
		S_MOD  = 10'b0000001000,
		S_MCHK = 10'b0000010000,
		S_SRD  = 10'b0000100000,
		S_SCHK = 10'b0001000000,
		S_CRD  = 10'b0010000000,
		S_CWR  = 10'b0100000000,
		S_DONE = 10'b1000000000
	} state_t;

	state_t st_q, st_n;

	assign req_ready = (st_q == S_IDLE);

	always_comb begin
		cmd  = '0;
		st_n = st_q;
		case (st_q)
			S_CLR: begin
				cmd.clr_step = 1'b1;
				if (sts.clr_last) begin
					st_n = S_IDLE;
				end
			end
			S_IDLE: begin
				if (req_valid) begin
					cmd.accept = 1'b1;
					st_n = S_DEC;
				end
			end
			S_DEC: begin
				if (!sts.tid_ok) begin
					cmd.set_res    = 1'b1;
					cmd.res_status = sts.commit ? ST_COMMITTED : ST_CONFLICT;
					cmd.res_sel    = SEL_ZERO;
					st_n = S_DONE;
				end else if (sts.commit) begin
					if (sts.fill_zero) begin
						cmd.set_res    = 1'b1;
						cmd.res_status = ST_COMMITTED;
						cmd.res_sel    = SEL_FILL;
						cmd.fill_clear = 1'b1;
						st_n = S_DONE;
					end else begin
						cmd.commit_start = 1'b1;
						st_n = S_CRD;
					end
				end else if (sts.full) begin
					cmd.set_res    = 1'b1;
					cmd.res_status = ST_FULL;
					cmd.res_sel    = SEL_ZERO;
					st_n = S_DONE;
				end else begin
					cmd.mod_start = 1'b1;
					st_n = S_MOD;
				end
			end
			S_MOD: begin
				if (sts.mod_done) begin
					cmd.mark_rd = 1'b1;
					st_n = S_MCHK;
				end
			end
			S_MCHK: begin
				if (sts.owner_free) begin
					cmd.mark_write = 1'b1;
					cmd.log_append = 1'b1;
					cmd.set_res    = 1'b1;
					cmd.res_status = ST_APPENDED;
					cmd.res_sel    = SEL_FILL;
					st_n = S_DONE;
				end else if (!sts.owner_mine) begin
					cmd.set_res    = 1'b1;
					cmd.res_status = ST_CONFLICT;
					cmd.res_sel    = SEL_ZERO;
					st_n = S_DONE;
				end else if (sts.slot_lt_fill) begin
					cmd.set_search = 1'b1;
					st_n = S_SRD;
				end else begin
					cmd.log_append = 1'b1;
					cmd.set_res    = 1'b1;
					cmd.res_status = ST_APPENDED;
					cmd.res_sel    = SEL_FILL;
					st_n = S_DONE;
				end
			end
			S_SRD: begin
				cmd.log_rd = 1'b1;
				st_n = S_SCHK;
			end
			S_SCHK: begin
				if (sts.hit) begin
					cmd.set_res    = 1'b1;
					cmd.res_status = ST_LOGGED;
					cmd.res_sel    = SEL_IDX;
					st_n = S_DONE;
				end else if (!sts.idx_last) begin
					cmd.idx_inc = 1'b1;
					st_n = S_SRD;
				end else begin
					cmd.log_append = 1'b1;
					cmd.set_res    = 1'b1;
					cmd.res_status = ST_APPENDED;
					cmd.res_sel    = SEL_FILL;
					st_n = S_DONE;
				end
			end
			S_CRD: begin
				cmd.log_rd = 1'b1;
				st_n = S_CWR;
			end
			S_CWR: begin
				cmd.release_mark = 1'b1;
				if (sts.idx_last) begin
					cmd.fill_clear = 1'b1;
					cmd.set_res    = 1'b1;
					cmd.res_status = ST_COMMITTED;
					cmd.res_sel    = SEL_FILL;
					st_n = S_DONE;
				end else begin
					cmd.idx_inc = 1'b1;
					st_n = S_CRD;
				end
			end
			S_DONE: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					st_n = S_IDLE;
				end
			end
			default: begin
				st_n = S_CLR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_CLR;
		end else begin
			st_q <= st_n;
		end
	end

endmodule

>>> src/wsml_dp.sv
// Datapath: item registers, fill counters, marker and log memories, result register.
// Depends on wsml_pkg and wsml_mod; steered by cmd_t from wsml_ctrl.
module wsml_dp #(
	parameter int MARKER_ENTRIES   = wsml_pkg::MARKER_ENTRIES_DEF,
	parameter int LOG_DEPTH        = wsml_pkg::LOG_DEPTH_DEF,
	parameter int THREAD_COUNT     = wsml_pkg::THREAD_COUNT_DEF,
	parameter int LINE_OFFSET_BITS = wsml_pkg::LINE_OFFSET_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  wsml_pkg::req_item_t req,
	output logic                rsp_valid,
	input  logic                rsp_ready,
	output wsml_pkg::rsp_item_t rsp,
	input  wsml_pkg::cmd_t      cmd,
	output wsml_pkg::sts_t      sts
);
	import wsml_pkg::*;

	localparam int MIDX_W = $clog2(MARKER_ENTRIES);
	localparam int SLOT_W = $clog2(LOG_DEPTH);
	localparam int FILL_W = $clog2(LOG_DEPTH + 1);
	localparam int TIDX_W = (THREAD_COUNT > 1) ? $clog2(THREAD_COUNT) : 1;
	localparam int LINE_W = ADDR_W - LINE_OFFSET_BITS;
	localparam int OWN_W  = TID_W + 1;          // free flag on top
	localparam int LOG_W  = LINE_W + MIDX_W;    // line and its marker index
	localparam int LOG_N  = 1 << (TIDX_W + SLOT_W);

	// item
	logic              kind_q;
	logic [TID_W-1:0]  tid_q;
	logic [LINE_W-1:0] line_q;
	logic [TIDX_W-1:0] tidx;
	logic              tid_ok;

	// fill counters
	logic [FILL_W-1:0] fill_q [THREAD_COUNT];
	logic [FILL_W-1:0] fill_cur;

	// index unit
	logic              mod_done;
	logic [MIDX_W-1:0] midx;

	// memories and read registers
	logic [OWN_W-1:0]  owner_mem [MARKER_ENTRIES];
	logic [SLOT_W-1:0] slot_mem  [MARKER_ENTRIES];
	logic [LOG_W-1:0]  log_mem   [LOG_N];
	logic [OWN_W-1:0]  rd_owner_q;
	logic [SLOT_W-1:0] rd_slot_q;
	logic [LOG_W-1:0]  rd_log_q;

	logic [MIDX_W-1:0]        clr_idx_q;
	logic [SLOT_W-1:0]        idx_q;
	logic                     own_we;
	logic [MIDX_W-1:0]        own_wa;
	logic [OWN_W-1:0]         own_wd;
	logic [TIDX_W+SLOT_W-1:0] log_wa, log_ra;

	logic [STATUS_W-1:0]   pend_status_q;
	logic [SLOT_OUT_W-1:0] pend_slot_q;
	logic                  rsp_valid_q;
	rsp_item_t             rsp_q;

	assign tidx     = TIDX_W'(tid_q);
	assign tid_ok   = 32'(tid_q) < THREAD_COUNT;
	assign fill_cur = tid_ok ? fill_q[tidx] : '0;

	wsml_mod #(
		.MARKER_ENTRIES(MARKER_ENTRIES),
		.LINE_W        (LINE_W)
	) u_mod (
		.clk   (clk),
		.arst_n(arst_n),
		.start (cmd.mod_start),
		.line  (line_q),
		.done  (mod_done),
		.rem   (midx)
	);

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			kind_q <= req.kind;
			tid_q  <= req.thread_id;
			line_q <= req.byte_address[ADDR_W-1:LINE_OFFSET_BITS];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int t = 0; t < THREAD_COUNT; t++) begin
				fill_q[t] <= '0;
			end
		end else if (cmd.log_append) begin
			fill_q[tidx] <= fill_cur + 1'b1;
		end else if (cmd.fill_clear && tid_ok) begin
			fill_q[tidx] <= '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_idx_q <= '0;
		end else if (cmd.clr_step) begin
			clr_idx_q <= clr_idx_q + 1'b1;
		end
	end

	// marker owner write port: clear sweep, claim, release
	always_comb begin
		own_we = cmd.clr_step | cmd.mark_write | cmd.release_mark;
		own_wa = clr_idx_q;
		own_wd = {1'b1, TID_W'(0)};
		if (cmd.mark_write) begin
			own_wa = midx;
			own_wd = {1'b0, tid_q};
		end else if (cmd.release_mark) begin
			own_wa = rd_log_q[MIDX_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (own_we) begin
			owner_mem[own_wa] <= own_wd;
		end
		if (cmd.mark_rd) begin
			rd_owner_q <= owner_mem[midx];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mark_write) begin
			slot_mem[midx] <= fill_cur[SLOT_W-1:0];
		end
		if (cmd.mark_rd) begin
			rd_slot_q <= slot_mem[midx];
		end
	end

	assign log_wa = {tidx, fill_cur[SLOT_W-1:0]};
	assign log_ra = {tidx, idx_q};

	always_ff @(posedge clk) begin
		if (cmd.log_append) begin
			log_mem[log_wa] <= {line_q, midx};
		end
		if (cmd.log_rd) begin
			rd_log_q <= log_mem[log_ra];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.set_search) begin
			idx_q <= rd_slot_q;
		end else if (cmd.commit_start) begin
			idx_q <= '0;
		end else if (cmd.idx_inc) begin
			idx_q <= idx_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.set_res) begin
			pend_status_q <= cmd.res_status;
			case (cmd.res_sel)
				SEL_FILL: pend_slot_q <= SLOT_OUT_W'(fill_cur);
				SEL_IDX:  pend_slot_q <= SLOT_OUT_W'(idx_q);
				default:  pend_slot_q <= '0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			rsp_q.status   <= pend_status_q;
			rsp_q.log_slot <= pend_slot_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_comb begin
		sts.clr_last     = clr_idx_q == MIDX_W'(MARKER_ENTRIES - 1);
		sts.tid_ok       = tid_ok;
		sts.commit       = kind_q;
		sts.full         = fill_cur >= FILL_W'(LOG_DEPTH);
		sts.fill_zero    = fill_cur == '0;
		sts.mod_done     = mod_done;
		sts.owner_free   = rd_owner_q[OWN_W-1];
		sts.owner_mine   = !rd_owner_q[OWN_W-1] && (rd_owner_q[TID_W-1:0] == tid_q);
		sts.slot_lt_fill = FILL_W'(rd_slot_q) < fill_cur;
		sts.hit          = rd_log_q[LOG_W-1:MIDX_W] == line_q;
		sts.idx_last     = (FILL_W'(idx_q) + 1'b1) >= fill_cur;
		sts.out_free     = !rsp_valid_q || rsp_ready;
	end

endmodule

>>> src/wsml_checker.sv
// Port-level checks for the write-set marker log, bound to the top level.
// Depends on wsml_pkg and write_set_marker_log_unit.
module wsml_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                req_valid,
	input logic                req_ready,
	input wsml_pkg::req_item_t req,
	input logic                rsp_valid,
	input logic                rsp_ready,
	input wsml_pkg::rsp_item_t rsp
);
	import wsml_pkg::*;

	// held response beat stays put
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("response changed while stalled");

	// one request in flight
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while busy");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp.status == ST_APPENDED || rsp.status == ST_LOGGED ||
			rsp.status == ST_CONFLICT || rsp.status == ST_FULL ||
			rsp.status == ST_COMMITTED))
		else $error("bad status code");

	a_refusal_slot: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.status == ST_CONFLICT || rsp.status == ST_FULL)
			|-> rsp.log_slot == '0)
		else $error("refused write carries a slot");

endmodule

bind write_set_marker_log_unit wsml_checker u_wsml_checker (.*);
